// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Each macro expands to one labeled concurrent assertion that is held off
// while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define BBRA_ASSERT_IMPLY(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define BBRA_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bbra_pkg.sv =====
package bbra_pkg;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 12;
    localparam int RUN_W   = 12;
    localparam int STS_W   = 2;
    localparam int LIMIT_W = 13;
    localparam int REG_W   = 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes
    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd1;
    localparam logic [STS_W-1:0] STS_NONE  = 2'd2;

    // Register indexes
    localparam logic [REG_W-1:0] REG_FIRST_BLOCK  = 1'd0;
    localparam logic [REG_W-1:0] REG_LIMIT_BLOCKS = 1'd1;

    // Register reset values
    localparam logic [IDX_W-1:0]   FIRST_BLOCK_RST  = 12'd2;
    localparam logic [LIMIT_W-1:0] LIMIT_BLOCKS_RST = 13'd4096;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] block_index;
        logic [RUN_W-1:0] run_length;
    } req_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [IDX_W-1:0] run_start;
        logic [RUN_W-1:0] run_count;
    } rsp_t;

    typedef struct packed {
        logic [REG_W-1:0]   reg_index;
        logic [LIMIT_W-1:0] wr_data;
    } cfg_t;

endpackage

// ===== design/bbra_chan_if.sv =====
interface bbra_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/bitmap_block_run_allocator.sv =====
// Bitmap block run allocator.
// req carries commands (allocate run, mark used, mark free); rsp returns one
// result per command with status, run_start and run_count. cfg writes the
// first_block and limit_blocks registers at any time; it is always ready.
// A transfer happens when valid and ready are both high.
// After reset the bitmap is swept to zero, one word per cycle; req.ready
// stays low meanwhile. Mark used/free reads the word, writes it back, then
// posts the result. Allocate reads the bitmap word by word from first_block
// (read, then scan), scanning again inside the current word each time a used
// block ends a candidate run, then reads and writes back each word it marks
// used. Scan and marking share the single memory port pair.
// One command is in flight at a time. The result sits in an output register,
// so the next command is accepted while rsp is stalled; a finished result
// waits in the block until the output register frees up.
module bitmap_block_run_allocator #(
    parameter int NUM_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    bbra_chan_if.sink   req,
    bbra_chan_if.source rsp,
    bbra_chan_if.sink   cfg
);

    // WORD_BITS is a power of two
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int NBW       = $clog2(NUM_BLOCKS + 1);
    localparam int PW        = ((NBW > bbra_pkg::LIMIT_W) ? NBW : bbra_pkg::LIMIT_W) + 1;
    localparam int RW        = bbra_pkg::RUN_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_SCAN,
        S_MRD,
        S_MWR,
        S_POST
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              clr_addr_reg, clr_addr_next;
    logic [PW-1:0]              pos_reg, pos_next;
    logic [PW-1:0]              start_reg, start_next;
    logic [RW-1:0]              n_reg, n_next;
    logic [RW-1:0]              want_reg, want_next;
    logic [RW-1:0]              best_reg, best_next;
    logic [PW-1:0]              best_start_reg, best_start_next;
    logic [PW-1:0]              mark_pos_reg, mark_pos_next;
    logic [RW-1:0]              mark_rem_reg, mark_rem_next;
    logic                       mark_set_reg, mark_set_next;
    bbra_pkg::rsp_t             res_reg, res_next;
    bbra_pkg::rsp_t             out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bbra_pkg::IDX_W-1:0] first_reg, first_next;
    logic [bbra_pkg::LIMIT_W-1:0] limit_reg, limit_next;

    // Bitmap memory
    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] mem_wdata;

    // Scan datapath
    logic [PW-1:0]  limit_ext;
    logic [PW-1:0]  eff_limit;
    logic [PW-1:0]  first_ext;
    logic [PW-1:0]  blk_ext;
    logic [OW:0]    free_cnt;
    logic           hit;
    logic [RW-1:0]  k_ext;
    logic [RW-1:0]  rem;
    logic           success;
    logic [PW-1:0]  fail_pos;
    logic           fail;
    logic [RW-1:0]  cand;
    logic [PW-1:0]  next_start;
    logic           cont_next;
    logic           cont_first;
    logic           same_word;

    // Marking datapath
    logic [OW-1:0]        mark_off;
    logic [OW:0]          mark_room;
    logic [OW:0]          mark_cnt;
    logic [WORD_BITS:0]   mark_ones;
    logic [WORD_BITS-1:0] mark_mask;
    logic [RW-1:0]        mark_rem_left;

    function automatic logic may_start(input logic [PW-1:0] s, input logic [PW-1:0] lim);
        may_start = ((s + PW'(1)) < lim) && (s < PW'(NUM_BLOCKS));
    endfunction

    assign limit_ext = PW'(limit_reg);
    assign eff_limit = (limit_ext < PW'(NUM_BLOCKS)) ? limit_ext : PW'(NUM_BLOCKS);
    assign first_ext = PW'(first_reg);
    assign blk_ext   = PW'(req.payload.block_index);

    bbra_run_scan #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW)
    ) u_scan (
        .word      (rd_data_reg),
        .offset    (pos_reg[OW-1:0]),
        .base      ({pos_reg[PW-1:OW], {OW{1'b0}}}),
        .eff_limit (eff_limit),
        .free_cnt  (free_cnt),
        .hit       (hit)
    );

    // Step one candidate run through the current word
    assign k_ext      = RW'(free_cnt);
    assign rem        = want_reg - n_reg;
    assign success    = k_ext >= rem;
    assign fail_pos   = pos_reg + PW'(free_cnt);
    assign fail       = hit || (fail_pos >= eff_limit);
    assign cand       = n_reg + k_ext;
    assign next_start = fail_pos + PW'(1);
    assign cont_next  = may_start(next_start, limit_ext);
    assign cont_first = may_start(first_ext, limit_ext);
    assign same_word  = next_start[PW-1:OW] == pos_reg[PW-1:OW];

    // Build the bit mask for the blocks of the run inside this word
    assign mark_off      = mark_pos_reg[OW-1:0];
    assign mark_room     = (OW+1)'(WORD_BITS) - {1'b0, mark_off};
    assign mark_cnt      = (mark_rem_reg < RW'(mark_room)) ? (OW+1)'(mark_rem_reg) : mark_room;
    assign mark_ones     = ~({(WORD_BITS+1){1'b1}} << mark_cnt);
    assign mark_mask     = mark_ones[WORD_BITS-1:0] << mark_off;
    assign mark_rem_left = mark_rem_reg - RW'(mark_cnt);

    assign req.ready   = state_reg == S_IDLE;
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Sequence clear, scan and marking
    always_comb
    begin
        logic [RW-1:0] best_sel;
        logic [PW-1:0] best_start_sel;

        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        pos_next        = pos_reg;
        start_next      = start_reg;
        n_next          = n_reg;
        want_next       = want_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        mark_pos_next   = mark_pos_reg;
        mark_rem_next   = mark_rem_reg;
        mark_set_next   = mark_set_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        first_next      = first_reg;
        limit_next      = limit_reg;
        rd_en           = 1'b0;
        rd_addr         = pos_reg[OW +: AW];
        wr_en           = 1'b0;
        wr_addr         = mark_pos_reg[OW +: AW];
        mem_wdata       = mark_set_reg ? (rd_data_reg | mark_mask)
                                       : (rd_data_reg & ~mark_mask);
        best_sel        = best_reg;
        best_start_sel  = best_start_reg;

        // Take register writes
        if (cfg.valid)
        begin
            unique case (cfg.payload.reg_index)
                bbra_pkg::REG_FIRST_BLOCK:
                begin
                    first_next = cfg.payload.wr_data[bbra_pkg::IDX_W-1:0];
                end
                bbra_pkg::REG_LIMIT_BLOCKS:
                begin
                    limit_next = cfg.payload.wr_data;
                end
                default:
                begin
                    limit_next = limit_reg;
                end
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_addr   = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next = '{status: bbra_pkg::STS_OK, run_start: '0, run_count: '0};
                    case (req.payload.command) inside
                        bbra_pkg::CMD_ALLOC:
                        begin
                            want_next       = req.payload.run_length;
                            best_next       = '0;
                            best_start_next = '0;
                            pos_next        = first_ext;
                            start_next      = first_ext;
                            n_next          = '0;
                            if (req.payload.run_length == '0 || !cont_first)
                            begin
                                res_next.status = bbra_pkg::STS_NONE;
                                state_next      = S_POST;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        bbra_pkg::CMD_SET, bbra_pkg::CMD_CLEAR:
                        begin
                            if (blk_ext >= eff_limit)
                            begin
                                res_next.status = bbra_pkg::STS_RANGE;
                                state_next      = S_POST;
                            end
                            else
                            begin
                                mark_pos_next = blk_ext;
                                mark_rem_next = RW'(1);
                                mark_set_next = req.payload.command == bbra_pkg::CMD_SET;
                                state_next    = S_MRD;
                            end
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                if (success)
                begin
                    best_next          = want_reg;
                    best_start_next    = start_reg;
                    mark_pos_next      = start_reg;
                    mark_rem_next      = want_reg;
                    mark_set_next      = 1'b1;
                    res_next.status    = bbra_pkg::STS_OK;
                    res_next.run_start = start_reg[bbra_pkg::IDX_W-1:0];
                    res_next.run_count = want_reg;
                    state_next         = S_MRD;
                end
                else if (fail)
                begin
                    // Close the candidate and keep the longest so far
                    if (cand > best_reg)
                    begin
                        best_sel       = cand;
                        best_start_sel = start_reg;
                    end
                    best_next       = best_sel;
                    best_start_next = best_start_sel;
                    if (cont_next)
                    begin
                        pos_next   = next_start;
                        start_next = next_start;
                        n_next     = '0;
                        state_next = same_word ? S_SCAN : S_RD;
                    end
                    else if (best_sel == '0)
                    begin
                        res_next.status = bbra_pkg::STS_NONE;
                        state_next      = S_POST;
                    end
                    else
                    begin
                        mark_pos_next      = best_start_sel;
                        mark_rem_next      = best_sel;
                        mark_set_next      = 1'b1;
                        res_next.status    = bbra_pkg::STS_OK;
                        res_next.run_start = best_start_sel[bbra_pkg::IDX_W-1:0];
                        res_next.run_count = best_sel;
                        state_next         = S_MRD;
                    end
                end
                else
                begin
                    // Run reaches the word end: continue in the next word
                    n_next     = cand;
                    pos_next   = fail_pos;
                    state_next = S_RD;
                end
            end

            S_MRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = mark_pos_reg[OW +: AW];
                state_next = S_MWR;
            end

            S_MWR:
            begin
                wr_en         = 1'b1;
                mark_pos_next = mark_pos_reg + PW'(mark_cnt);
                mark_rem_next = mark_rem_left;
                state_next    = (mark_rem_left == '0) ? S_POST : S_MRD;
            end

            S_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, registers and the output slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            pos_reg        <= '0;
            start_reg      <= '0;
            n_reg          <= '0;
            want_reg       <= '0;
            best_reg       <= '0;
            best_start_reg <= '0;
            mark_pos_reg   <= '0;
            mark_rem_reg   <= '0;
            mark_set_reg   <= 1'b0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            first_reg      <= bbra_pkg::FIRST_BLOCK_RST;
            limit_reg      <= bbra_pkg::LIMIT_BLOCKS_RST;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            n_reg          <= n_next;
            want_reg       <= want_next;
            best_reg       <= best_next;
            best_start_reg <= best_start_next;
            mark_pos_reg   <= mark_pos_next;
            mark_rem_reg   <= mark_rem_next;
            mark_set_reg   <= mark_set_next;
            res_reg        <= res_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            first_reg      <= first_next;
            limit_reg      <= limit_next;
        end
    end

    // Write and read the bitmap words
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

endmodule

// ===== design/bbra_run_scan.sv =====
// Count the free blocks from a bit offset within one bitmap word.
// Blocks at or past the effective limit count as used.
module bbra_run_scan #(
    parameter int WORD_BITS = 32,
    parameter int PW        = 14,
    localparam int OW       = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [OW-1:0]        offset,
    input  logic [PW-1:0]        base,
    input  logic [PW-1:0]        eff_limit,
    output logic [OW:0]          free_cnt,
    output logic                 hit
);

    logic [PW-1:0]        rel;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] used;
    logic [WORD_BITS:0]   probe;

    // Force blocks past the limit to used, then align to the offset
    always_comb
    begin
        rel = eff_limit - base;
        if (eff_limit <= base)
        begin
            lim_mask = '1;
        end
        else if (rel >= PW'(WORD_BITS))
        begin
            lim_mask = '0;
        end
        else
        begin
            lim_mask = {WORD_BITS{1'b1}} << rel[OW-1:0];
        end
        used  = word | lim_mask;
        probe = {1'b1, used} >> offset;
    end

    // Find the lowest used bit; the top marker stops the count at word end
    always_comb
    begin
        free_cnt = (OW+1)'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (probe[i])
            begin
                free_cnt = (OW+1)'(i);
            end
        end
    end

    assign hit = free_cnt < ((OW+1)'(WORD_BITS) - {1'b0, offset});

endmodule

// ===== design/bbra_checker.sv =====
`include "assert_macros.svh"

module bbra_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input bbra_pkg::rsp_t rsp_payload
);

    logic rsp_stall;
    logic req_xfer;
    logic rsp_fail;
    logic rsp_empty;

    assign rsp_stall = rsp_valid && !rsp_ready;
    assign req_xfer  = req_valid && req_ready;
    assign rsp_fail  = rsp_valid && rsp_payload.status != bbra_pkg::STS_OK;
    assign rsp_empty = rsp_payload.run_start == '0 && rsp_payload.run_count == '0;

    // A stalled result stays offered
    `BBRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid, "rsp valid dropped")

    // A stalled result keeps its fields
    `BBRA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(rsp_payload), "rsp changed")

    // One command in flight: no transfer right after a transfer
    `BBRA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_xfer, !req_ready, "req ready too soon")

    // A failed command grants nothing
    `BBRA_ASSERT_IMPLY(a_fail_empty, clk, rst_n, rsp_fail, rsp_empty, "failed result has a run")

endmodule

bind bitmap_block_run_allocator bbra_checker u_bbra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int MAP_BLOCKS    = 4096;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = MAP_BLOCKS / MAP_WORD_BITS;
    localparam int QUIET_LIMIT   = 40000;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 20;

    // The block answers this code with a plain status and changes nothing
    localparam logic [bbra_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic [1:0] {ROW_CMD, ROW_TYPED, ROW_CFG} row_kind_t;

    // One row of the directed table: a command, a command with its answer
    // typed in, or a new register setting (arg_a first block, arg_b limit)
    typedef struct packed {
        row_kind_t                    kind;
        logic [bbra_pkg::CMD_W-1:0]   command;
        logic [bbra_pkg::LIMIT_W-1:0] arg_a;
        logic [bbra_pkg::LIMIT_W-1:0] arg_b;
        bbra_pkg::rsp_t               typed_rsp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bbra_chan_if #(.payload_t(bbra_pkg::req_t)) req_ch ();
    bbra_chan_if #(.payload_t(bbra_pkg::rsp_t)) rsp_ch ();
    bbra_chan_if #(.payload_t(bbra_pkg::cfg_t)) cfg_ch ();

    bitmap_block_run_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the bitmap and the registers
    bit [MAP_WORD_BITS-1:0]       map_words [MAP_WORDS];
    logic [bbra_pkg::IDX_W-1:0]   cur_first;
    logic [bbra_pkg::LIMIT_W-1:0] cur_limit;

    bbra_pkg::rsp_t grant_queue [$];
    dir_row_t       dir_rows [$];
    bbra_pkg::rsp_t oldest_grant;
    idle_mode_t     idle_mode = IDLE_NONE;

    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int error_count  = 0;
    int results_seen = 0;
    int commands_sent    = 0;
    int settings_applied = 0;
    int allocs_full    = 0;
    int allocs_partial = 0;
    int allocs_empty   = 0;
    int marks_done     = 0;
    int range_hits     = 0;
    int unused_cmds    = 0;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int idx,
                               input logic [11:0] got, input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                      idx, name, got, want));
    endtask

    function automatic bit block_is_free(input int unsigned b);
        if (b >= cur_limit || b >= MAP_BLOCKS)
            return 1'b0;
        return map_words[b / MAP_WORD_BITS][b % MAP_WORD_BITS] == 1'b0;
    endfunction

    function automatic void mark_block(input int unsigned b, input bit used);
        if (b < MAP_BLOCKS)
            map_words[b / MAP_WORD_BITS][b % MAP_WORD_BITS] = used;
    endfunction

    // Compute the answer to one command and apply it to the shadow bitmap
    function automatic bbra_pkg::rsp_t predict_grant(input bbra_pkg::req_t item);
        bbra_pkg::rsp_t res;
        int unsigned    start, best, best_start, n, i;
        res = '0;
        case (item.command) inside
            bbra_pkg::CMD_ALLOC:
            begin
                start      = 32'(cur_first);
                best       = 0;
                best_start = 0;
                // first fit, else the longest run; a failed candidate resumes past the used block
                while (start + 1 < cur_limit)
                begin
                    n = 0;
                    while (n < item.run_length && block_is_free(start + n))
                        n++;
                    if (n > best)
                    begin
                        best       = n;
                        best_start = start;
                    end
                    if (n == item.run_length)
                        break;
                    start += n + 1;
                end
                if (best == 0)
                begin
                    res.status = bbra_pkg::STS_NONE;
                    allocs_empty++;
                end
                else
                begin
                    for (i = 0; i < best; i++)
                        mark_block(best_start + i, 1'b1);
                    res.status    = bbra_pkg::STS_OK;
                    res.run_start = best_start[bbra_pkg::IDX_W-1:0];
                    res.run_count = best[bbra_pkg::RUN_W-1:0];
                    if (best == item.run_length)
                        allocs_full++;
                    else
                        allocs_partial++;
                end
            end
            bbra_pkg::CMD_SET, bbra_pkg::CMD_CLEAR:
            begin
                if (item.block_index >= cur_limit)
                begin
                    res.status = bbra_pkg::STS_RANGE;
                    range_hits++;
                end
                else
                begin
                    mark_block(32'(item.block_index), item.command == bbra_pkg::CMD_SET);
                    res.status = bbra_pkg::STS_OK;
                    marks_done++;
                end
            end
            default:
            begin
                res.status = bbra_pkg::STS_OK;
                unused_cmds++;
            end
        endcase
        return res;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [bbra_pkg::CMD_W-1:0] command,
                           input int a, input int b,
                           input logic [bbra_pkg::STS_W-1:0] st = bbra_pkg::STS_OK,
                           input int rs = 0, input int rc = 0);
        dir_row_t row;
        row.kind                = kind;
        row.command             = command;
        row.arg_a               = 13'(a);
        row.arg_b               = 13'(b);
        row.typed_rsp.status    = st;
        row.typed_rsp.run_start = 12'(rs);
        row.typed_rsp.run_count = 12'(rc);
        dir_rows.push_back(row);
    endtask

    // Offer one command, hold it until the transfer, then record its answer
    task automatic offer_command(input bbra_pkg::req_t item, input bit typed,
                                 input bbra_pkg::rsp_t typed_rsp);
        int             rest_pct;
        bbra_pkg::rsp_t predicted;
        rest_pct = (idle_mode == IDLE_SENDER) ? 72 : (idle_mode == IDLE_BOTH) ? 36 : 0;
        while ($urandom_range(99, 0) < rest_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        @(negedge clk);
        while (req_ch.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
        predicted = predict_grant(item);
        grant_queue.push_back(typed ? typed_rsp : predicted);
        commands_sent++;
    endtask

    // Drop valid and wait until every outstanding answer is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers while the block is idle
    task automatic apply_setting(input logic [bbra_pkg::IDX_W-1:0] first,
                                 input logic [bbra_pkg::LIMIT_W-1:0] limit);
        bbra_pkg::cfg_t word;
        int             k;
        drain_results();
        for (k = 0; k < 2; k++)
        begin
            word.reg_index = (k == 0) ? bbra_pkg::REG_FIRST_BLOCK : bbra_pkg::REG_LIMIT_BLOCKS;
            word.wr_data   = (k == 0) ? {1'b0, first} : limit;
            cfg_ch.valid   <= 1'b1;
            cfg_ch.payload <= word;
            @(negedge clk);
            while (cfg_ch.ready !== 1'b1)
                @(negedge clk);
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        cur_first = first;
        cur_limit = limit;
        settings_applied++;
    endtask

    // One random phase under a given setting and idle mode
    task automatic run_phase(input logic [bbra_pkg::IDX_W-1:0] first,
                             input logic [bbra_pkg::LIMIT_W-1:0] limit,
                             input idle_mode_t mode, input int count, input bit long_hold);
        bbra_pkg::req_t item;
        int unsigned    span, roll;
        int             n;
        apply_setting(first, limit);
        idle_mode <= mode;
        if (long_hold)
            hold_asked <= hold_asked + 1;
        for (n = 0; n < count; n++)
        begin
            span = (cur_limit > MAP_BLOCKS) ? MAP_BLOCKS : cur_limit;
            roll = $urandom_range(99, 0);
            item.command = (roll < 40) ? bbra_pkg::CMD_ALLOC :
                           (roll < 60) ? bbra_pkg::CMD_SET :
                           (roll < 95) ? bbra_pkg::CMD_CLEAR : CMD_UNUSED;
            // mostly inside the map, some just past the limit, some anywhere
            roll = $urandom_range(99, 0);
            if (roll < 70 && span != 0)
                item.block_index = 12'($urandom_range(span - 1, 0));
            else if (roll < 80)
                item.block_index = 12'(span + $urandom_range(3, 0));
            else
                item.block_index = 12'($urandom());
            // mostly short runs, a few zero, huge or maximal
            roll = $urandom_range(99, 0);
            if (roll < 5)
                item.run_length = '0;
            else if (roll < 65)
                item.run_length = 12'($urandom_range(8, 1));
            else if (roll < 85)
                item.run_length = 12'($urandom_range(64, 9));
            else if (roll < 95)
                item.run_length = 12'($urandom());
            else
                item.run_length = '1;
            offer_command(item, 1'b0, '0);
            // pause now and then until the block has answered everything
            if (n % 100 == 99)
                drain_results();
        end
    endtask

    // Receiver: random stalls per idle mode, plus an occasional long hold
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served  <= hold_asked;
            hold_left    <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECEIVER: rsp_ch.ready <= ($urandom_range(99, 0) >= 72);
                IDLE_BOTH:     rsp_ch.ready <= ($urandom_range(99, 0) >= 36);
                default:       rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    // Compare each result transfer with the oldest expected answer
    always @(negedge clk)
    begin
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (grant_queue.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with nothing outstanding", results_seen));
            end
            else
            begin
                oldest_grant = grant_queue.pop_front();
                check_field("status", results_seen, 12'(rsp_ch.payload.status),
                            12'(oldest_grant.status));
                check_field("run_start", results_seen, rsp_ch.payload.run_start,
                            oldest_grant.run_start);
                check_field("run_count", results_seen, rsp_ch.payload.run_count,
                            oldest_grant.run_count);
            end
        end
    end

    // Watchdog: end the run after a long stretch with no transfer at all
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin : main
        bbra_pkg::req_t item;
        int             i;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        foreach (map_words[w])
            map_words[w] = '0;
        cur_first = bbra_pkg::FIRST_BLOCK_RST;
        cur_limit = bbra_pkg::LIMIT_BLOCKS_RST;

        // Directed table
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 5, bbra_pkg::STS_OK, 2, 5); // fresh map
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 0, bbra_pkg::STS_NONE);     // zero length
        add_row(ROW_TYPED, bbra_pkg::CMD_SET, 4095, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 4095, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_SET, 0, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 0, 0);
        add_row(ROW_CMD, bbra_pkg::CMD_ALLOC, 0, 4095);             // take the rest of the map
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 1, bbra_pkg::STS_NONE);     // no free block
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 3, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 5, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 6, 0);
        add_row(ROW_CMD, bbra_pkg::CMD_ALLOC, 0, 3);                // longest run instead
        add_row(ROW_TYPED, CMD_UNUSED, 4095, 4095);
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 2, 100);
        add_row(ROW_TYPED, bbra_pkg::CMD_SET, 100, 0, bbra_pkg::STS_RANGE);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 4000, 0, bbra_pkg::STS_RANGE);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 99, 0);
        add_row(ROW_CMD, bbra_pkg::CMD_ALLOC, 0, 4);                // last block not a start
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 2, 1);
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 5, bbra_pkg::STS_NONE);     // limit of one
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 2, 0);
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 5, bbra_pkg::STS_NONE);     // limit of zero
        add_row(ROW_TYPED, bbra_pkg::CMD_SET, 0, 0, bbra_pkg::STS_RANGE);
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 4095, 4096);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 4095, 0);
        // first block is the last block, which may not start a run
        add_row(ROW_TYPED, bbra_pkg::CMD_ALLOC, 0, 1, bbra_pkg::STS_NONE);
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 4090, 8191);
        add_row(ROW_TYPED, bbra_pkg::CMD_CLEAR, 4094, 0);
        add_row(ROW_CMD, bbra_pkg::CMD_ALLOC, 0, 8);                // blocks past the map are used
        add_row(ROW_CFG, bbra_pkg::CMD_ALLOC, 0, 4096);
        add_row(ROW_CMD, bbra_pkg::CMD_ALLOC, 0, 4095);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (i = 0; i < dir_rows.size(); i++)
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                apply_setting(dir_rows[i].arg_a[bbra_pkg::IDX_W-1:0], dir_rows[i].arg_b);
            end
            else
            begin
                item.command     = dir_rows[i].command;
                item.block_index = dir_rows[i].arg_a[bbra_pkg::IDX_W-1:0];
                item.run_length  = dir_rows[i].arg_b[bbra_pkg::RUN_W-1:0];
                offer_command(item, dir_rows[i].kind == ROW_TYPED, dir_rows[i].typed_rsp);
            end
        end

        // Random phases over several settings and idle modes
        run_phase(bbra_pkg::FIRST_BLOCK_RST, bbra_pkg::LIMIT_BLOCKS_RST, IDLE_NONE, 200, 1'b0);
        run_phase(12'd0, 13'd64, IDLE_SENDER, 250, 1'b0);
        run_phase(12'd17, 13'd300, IDLE_RECEIVER, 250, 1'b0);
        run_phase(12'($urandom_range(200, 0)), 13'($urandom_range(4096, 1)),
                  IDLE_BOTH, 200, 1'b0);
        run_phase(12'd4095, 13'd4096, IDLE_NONE, 60, 1'b0);
        run_phase(12'd0, 13'd4096, IDLE_SENDER, 200, 1'b0);
        run_phase(12'd1000, 13'd8191, IDLE_BOTH, 150, 1'b0);
        run_phase(12'd5, 13'd128, IDLE_RECEIVER, 200, 1'b1);
        run_phase(12'd3, 13'd40, IDLE_NONE, 150, 1'b0);
        drain_results();

        $display("run covered %0d commands, %0d settings: %0d marks, %0d out of range, %0d unused",
                 commands_sent, settings_applied, marks_done, range_hits, unused_cmds);
        $display("allocations: %0d in full, %0d shorter fallback, %0d granted nothing",
                 allocs_full, allocs_partial, allocs_empty);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/bbra_pkg.sv
design/bbra_chan_if.sv
design/bbra_run_scan.sv
design/bitmap_block_run_allocator.sv
design/bbra_checker.sv
bench/testbench.sv
